[rtl/core/tsb_pkg.sv]
`default_nettype none
package tsb_pkg;

  localparam int VertexDepthDefault = 1024;
  localparam int CoordW = 32;
  localparam int SlotW = 10;
  localparam int NormW = 16;
  localparam int EdgeW = 34;
  localparam int RedW = 21;
  localparam int CrossW = 44;
  localparam int CompW = 31;
  localparam int SumW = 62;
  localparam int RootW = 31;
  localparam int QuotW = 46;
  localparam int SumCW = 34;
  localparam int RecipW = 34;
  localparam int RecipLoW = 17;
  localparam logic [RecipW-1:0] Recip3 = 34'h2_AAAA_AAAB;
  localparam int Recip3Shift = 35;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TRI    = 2'd1,
    REQ_BOUNDS = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_EDGE,
    ST_CROSS,
    ST_CFIT,
    ST_SQ,
    ST_SQRT,
    ST_SUM,
    ST_DIV,
    ST_CENT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic write_vertex;
    logic load_req;
    logic [1:0] rd_sel;
    logic capture_corner;
    logic edge_step;
    logic cross_step;
    logic cfit_step;
    logic sq_step;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic cent_step;
    logic load_tri;
    logic load_bounds;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic cent_done;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/tsb_req_if.sv]
`default_nettype none
interface tsb_req_if;
  import tsb_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [SlotW-1:0] vertex_slot;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic [SlotW-1:0] corner_a;
  logic [SlotW-1:0] corner_b;
  logic [SlotW-1:0] corner_c;
  modport source (output valid, req_type, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, req_type, vertex_slot, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface tsb_res_if;
  import tsb_pkg::*;
  logic valid;
  logic ready;
  logic signed [NormW-1:0] normal_x;
  logic signed [NormW-1:0] normal_y;
  logic signed [NormW-1:0] normal_z;
  logic signed [CoordW-1:0] centroid_x;
  logic signed [CoordW-1:0] centroid_y;
  logic signed [CoordW-1:0] centroid_z;
  logic signed [CoordW-1:0] box_min_x;
  logic signed [CoordW-1:0] box_min_y;
  logic signed [CoordW-1:0] box_min_z;
  logic signed [CoordW-1:0] box_max_x;
  logic signed [CoordW-1:0] box_max_y;
  logic signed [CoordW-1:0] box_max_z;
  modport source (output valid, normal_x, normal_y, normal_z, centroid_x, centroid_y,
                  centroid_z, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, centroid_x, centroid_y,
                centroid_z, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, output ready);
endinterface
`default_nettype wire

[rtl/core/tsb_ram.sv]
`default_nettype none
module tsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

[rtl/core/tsb_ctrl.sv]
`default_nettype none
module tsb_ctrl
  import tsb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [1:0] in_type,
  input  wire logic    slot_ok,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);
  state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == ST_IDLE) && !out_valid;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_req = 1'b1;
          case (in_type)
            REQ_WRITE: cmd.write_vertex = slot_ok;
            REQ_TRI: state_next = ST_RD_A;
            REQ_BOUNDS: begin
              cmd.load_bounds = 1'b1;
              out_valid_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RD_A: begin
        cmd.rd_sel = 2'd0;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.rd_sel = 2'd1;
        cmd.capture_corner = 1'b1;
        state_next = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_sel = 2'd2;
        cmd.capture_corner = 1'b1;
        state_next = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.capture_corner = 1'b1;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.edge_step = 1'b1;
        state_next = ST_CFIT;
      end
      ST_CFIT: begin
        cmd.cross_step = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.cfit_step = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sqrt_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) begin
          cmd.sqrt_step = 1'b0;
          cmd.div_start = 1'b1;
          state_next = ST_CENT;
        end
      end
      ST_CENT: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          cmd.div_step = 1'b0;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.cent_step = 1'b1;
        if (status.cent_done) begin
          cmd.cent_step = 1'b0;
          cmd.load_tri = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/tsb_datapath.sv]
`default_nettype none
module tsb_datapath
  import tsb_pkg::*;
#(
  parameter int VertexDepth = VertexDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  output status_t   status,
  output logic      slot_ok,
  tsb_req_if.sink   req,
  tsb_res_if.source res
);
  localparam int AddrW = $clog2(VertexDepth);
  localparam int WordW = 3 * CoordW;
  localparam int CentMagW = SumCW - 1;
  localparam int CentProdW = SumCW + RecipLoW - 1;
  localparam int CentFullW = SumCW + RecipW - 1;

  logic [SlotW-1:0] corner [3];
  logic [AddrW-1:0] rd_addr;
  logic [WordW-1:0] rd_data;
  logic rd_ok, rd_ok_q;
  logic [1:0] cap_idx;
  logic signed [CoordW-1:0] vtx [3][3];
  logic signed [EdgeW-1:0] edge_v [6];
  logic signed [RedW-1:0] red [6];
  logic signed [CrossW-1:0] crs [3];
  logic signed [CompW-1:0] comp [3];
  logic [SumW-1:0] sq_sum;
  logic [SumW-1:0] rem;
  logic [RootW-1:0] root;
  logic [5:0] sq_cnt;
  logic [SumW+1:0] sq_trial;
  logic [QuotW-1:0] dnum [3];
  logic [QuotW-1:0] quot [3];
  logic [RootW:0] dpart [3];
  logic [5:0] dcnt;
  logic [1:0] ccnt;
  logic signed [SumCW-1:0] csum [3];
  logic [CentMagW-1:0] cmag [3];
  logic cneg [3];
  logic [CentProdW-1:0] cprod [3];
  logic [CentFullW-1:0] cfull [3];
  logic signed [CoordW-1:0] cent [3];
  logic signed [CoordW-1:0] bmin [3];
  logic signed [CoordW-1:0] bmax [3];
  logic any_written;
  logic signed [CoordW-1:0] wpos [3];
  logic [5:0] es, cs;
  logic [EdgeW-1:0] emag_or;
  logic [CrossW-1:0] cmag_or;

  function automatic logic [CrossW-1:0] mag(input logic signed [CrossW-1:0] v);
    mag = v[CrossW-1] ? CrossW'(-v) : v;
  endfunction

  assign slot_ok = 32'(req.vertex_slot) < VertexDepth;
  assign wpos[0] = req.pos_x;
  assign wpos[1] = req.pos_y;
  assign wpos[2] = req.pos_z;

  always_comb begin
    rd_addr = AddrW'(corner[cmd.rd_sel]);
    rd_ok = 32'(corner[cmd.rd_sel]) < VertexDepth;
  end

  tsb_ram #(.Width(WordW), .Depth(VertexDepth)) u_store (
    .clk(clk),
    .wr_en(cmd.write_vertex),
    .wr_addr(AddrW'(req.vertex_slot)),
    .wr_data({req.pos_z, req.pos_y, req.pos_x}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    emag_or = '0;
    for (int i = 0; i < 6; i++) begin
      emag_or = emag_or | EdgeW'(mag(CrossW'(edge_v[i])));
    end
    es = '0;
    for (int b = 20; b < EdgeW; b++) begin
      if (emag_or[b]) es = 6'(b - 19);
    end
    cmag_or = '0;
    for (int i = 0; i < 3; i++) begin
      cmag_or = cmag_or | mag(crs[i]);
    end
    cs = '0;
    for (int b = 30; b < CrossW; b++) begin
      if (cmag_or[b]) cs = 6'(b - 29);
    end
  end

  // The centroid divides by three through a multiply by the rounded-up
  // reciprocal 2^35 / 3, split into a low and a high half.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = SumCW'(vtx[0][i]) + SumCW'(vtx[1][i]) + SumCW'(vtx[2][i]);
      cfull[i] = ((CentFullW'(cmag[i]) * CentFullW'(Recip3[RecipW-1:RecipLoW])) << RecipLoW) +
                 CentFullW'(cprod[i]);
    end
  end

  assign sq_trial = {2'b00, rem} - {2'b00, (SumW'(root) << (sq_cnt + 6'd1))} -
                    ({2'b00, SumW'(1)} << (6'd2 * sq_cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      any_written <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        bmin[k] <= '0;
        bmax[k] <= '0;
      end
    end else if (cmd.write_vertex) begin
      any_written <= 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (!any_written || wpos[k] < bmin[k]) bmin[k] <= wpos[k];
        if (!any_written || wpos[k] > bmax[k]) bmax[k] <= wpos[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      corner[0] <= req.corner_a;
      corner[1] <= req.corner_b;
      corner[2] <= req.corner_c;
      cap_idx <= '0;
    end
    rd_ok_q <= rd_ok;
    if (cmd.capture_corner) begin
      vtx[cap_idx][0] <= rd_ok_q ? rd_data[CoordW-1:0] : '0;
      vtx[cap_idx][1] <= rd_ok_q ? rd_data[2*CoordW-1:CoordW] : '0;
      vtx[cap_idx][2] <= rd_ok_q ? rd_data[3*CoordW-1:2*CoordW] : '0;
      cap_idx <= cap_idx + 2'd1;
    end
    if (cmd.edge_step) begin
      for (int k = 0; k < 3; k++) begin
        edge_v[k] <= EdgeW'(vtx[2][k]) - EdgeW'(vtx[0][k]);
        edge_v[3+k] <= EdgeW'(vtx[1][k]) - EdgeW'(vtx[0][k]);
      end
    end
    if (cmd.cross_step) begin
      for (int i = 0; i < 6; i++) begin
        red[i] <= RedW'(edge_v[i][EdgeW-1] ?
                  -(EdgeW'(mag(CrossW'(edge_v[i])) >> es)) :
                  (EdgeW'(mag(CrossW'(edge_v[i])) >> es)));
      end
    end
    if (cmd.cfit_step) begin
      crs[0] <= CrossW'(red[1]) * CrossW'(red[5]) - CrossW'(red[2]) * CrossW'(red[4]);
      crs[1] <= CrossW'(red[2]) * CrossW'(red[3]) - CrossW'(red[0]) * CrossW'(red[5]);
      crs[2] <= CrossW'(red[0]) * CrossW'(red[4]) - CrossW'(red[1]) * CrossW'(red[3]);
    end
    if (cmd.sq_step) begin
      for (int i = 0; i < 3; i++) begin
        comp[i] <= CompW'(crs[i][CrossW-1] ? -(mag(crs[i]) >> cs) : (mag(crs[i]) >> cs));
      end
    end
    if (cmd.sqrt_start) begin
      sq_sum <= SumW'(comp[0]) * SumW'(comp[0]) + SumW'(comp[1]) * SumW'(comp[1]) +
                SumW'(comp[2]) * SumW'(comp[2]);
      sq_cnt <= 6'd31;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      if (sq_cnt == 6'd31) begin
        rem <= sq_sum;
        sq_cnt <= 6'd30;
      end else begin
        if (!sq_trial[SumW+1]) begin
          rem <= sq_trial[SumW-1:0];
          root <= root | (RootW'(1) << sq_cnt);
        end
        sq_cnt <= sq_cnt - 6'd1;
      end
    end
    if (cmd.div_start) begin
      for (int i = 0; i < 3; i++) begin
        dnum[i] <= QuotW'(mag(CrossW'(comp[i]))) << 14;
        quot[i] <= '0;
        dpart[i] <= '0;
      end
      dcnt <= 6'(QuotW);
      ccnt <= '0;
    end
    if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if ({dpart[i][RootW-1:0], dnum[i][QuotW-1]} >= {1'b0, root}) begin
          dpart[i] <= {dpart[i][RootW-1:0], dnum[i][QuotW-1]} - {1'b0, root};
          quot[i] <= {quot[i][QuotW-2:0], 1'b1};
        end else begin
          dpart[i] <= {dpart[i][RootW-1:0], dnum[i][QuotW-1]};
          quot[i] <= {quot[i][QuotW-2:0], 1'b0};
        end
        dnum[i] <= dnum[i] << 1;
      end
      dcnt <= dcnt - 6'd1;
    end
    if (cmd.cent_step) begin
      for (int i = 0; i < 3; i++) begin
        if (ccnt == 2'd0) begin
          cneg[i] <= csum[i][SumCW-1];
          cmag[i] <= CentMagW'(csum[i][SumCW-1] ? -csum[i] : csum[i]);
        end else if (ccnt == 2'd1) begin
          cprod[i] <= CentProdW'(cmag[i]) * CentProdW'(Recip3[RecipLoW-1:0]);
        end else begin
          cent[i] <= cneg[i] ? -CoordW'(cfull[i] >> Recip3Shift) :
                     CoordW'(cfull[i] >> Recip3Shift);
        end
      end
      ccnt <= ccnt + 2'd1;
    end
    if (cmd.load_tri) begin
      res.normal_x <= (root == '0) ? '0 :
        NormW'(comp[0][CompW-1] ? -quot[0] : quot[0]);
      res.normal_y <= (root == '0) ? '0 :
        NormW'(comp[1][CompW-1] ? -quot[1] : quot[1]);
      res.normal_z <= (root == '0) ? '0 :
        NormW'(comp[2][CompW-1] ? -quot[2] : quot[2]);
      res.centroid_x <= cent[0];
      res.centroid_y <= cent[1];
      res.centroid_z <= cent[2];
      res.box_min_x <= '0;
      res.box_min_y <= '0;
      res.box_min_z <= '0;
      res.box_max_x <= '0;
      res.box_max_y <= '0;
      res.box_max_z <= '0;
    end
    if (cmd.load_bounds) begin
      res.normal_x <= '0;
      res.normal_y <= '0;
      res.normal_z <= '0;
      res.centroid_x <= '0;
      res.centroid_y <= '0;
      res.centroid_z <= '0;
      res.box_min_x <= bmin[0];
      res.box_min_y <= bmin[1];
      res.box_min_z <= bmin[2];
      res.box_max_x <= bmax[0];
      res.box_max_y <= bmax[1];
      res.box_max_z <= bmax[2];
    end
  end

  assign status.sqrt_done = (sq_cnt == 6'd63);
  assign status.div_done = (dcnt == 6'd0) && !cmd.div_start;
  assign status.cent_done = (ccnt == 2'd3);
endmodule
`default_nettype wire

[rtl/core/triangle_setup_and_bounds_top.sv]
`default_nettype none
// Triangle setup and bounds engine. Vertex writes store a Q16.16 position and
// widen a running bounding box; bounds queries are answered in the cycle after
// they are accepted. A triangle request reads its three corners one after another
// from the vertex store and forms the edges, the cross product and its squared
// length, then runs a bit-serial square root and three parallel bit-serial
// divisions that share the root as divisor, followed by a centroid step. One
// request is in flight at a time; a result stays on the output until it is taken,
// and no request is accepted while it waits.
module triangle_setup_and_bounds_top
  import tsb_pkg::*;
#(
  parameter int VertexDepth = VertexDepthDefault
) (
  input wire logic clk,
  input wire logic rst,
  tsb_req_if.sink   req,
  tsb_res_if.source res
);
  cmd_t cmd;
  status_t status;
  logic slot_ok;

  tsb_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .in_type(req.req_type),
    .slot_ok(slot_ok),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .status(status),
    .cmd(cmd)
  );

  tsb_datapath #(.VertexDepth(VertexDepth)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .slot_ok(slot_ok),
    .req(req),
    .res(res)
  );
endmodule
`default_nettype wire
